// ===== rtl/rpteq_pkg.sv =====
`default_nettype none

package rpteq_pkg;

  // Field widths
  localparam int TASK_W  = 3;
  localparam int EVENT_W = 4;
  localparam int ARG_W   = 32;
  localparam int PTR_W   = 4;
  localparam int OTASK_W = 4;
  localparam int MAP_W   = 48;
  localparam int MAP_SEL_W = 6;

  localparam int TASK_COUNT  = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int STORE_AW    = TASK_W + PTR_W;
  localparam int SLOT_W      = EVENT_W + ARG_W;

  // Task code meaning "no task"
  localparam logic [OTASK_W-1:0] TASK_NONE = OTASK_W'(TASK_COUNT);

  // Result status codes
  typedef enum logic [2:0] {
    ST_POSTED    = 3'd0,
    ST_DELIVERED = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_INVALID   = 3'd4,
    ST_INFO      = 3'd5
  } status_t;

  // Operation codes on the input
  localparam logic [1:0] OP_POST   = 2'd0;
  localparam logic [1:0] OP_HANDLE = 2'd1;

  // Decoded command kinds
  typedef enum logic [1:0] {
    CMD_POST,
    CMD_POP,
    CMD_QUERY
  } cmd_kind_t;

  // Classified command handed from the front to the back
  typedef struct packed {
    cmd_kind_t             kind;
    logic [TASK_W-1:0]     task_sel;   // queue to touch
    logic [TASK_W-1:0]     owner;      // mapped owner of evt_id
    logic [EVENT_W-1:0]    evt_id;
    logic [ARG_W-1:0]      arg;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/rpteq_front.sv =====
`default_nettype none

module rpteq_front
  import rpteq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  input  wire logic [MAP_W-1:0]   cfg_data,
  input  wire logic [1:0]         op,
  input  wire logic [EVENT_W-1:0] evt_id,
  input  wire logic [ARG_W-1:0]   arg,
  input  wire logic [TASK_W-1:0]  task_id,
  output cmd_t                    cmd
);

  logic [MAP_W-1:0]     event_map;
  logic [MAP_SEL_W-1:0] map_lsb;
  logic [TASK_W-1:0]    owner;

  // Event-to-task map register
  always_ff @(posedge clk) begin
    if (rst) begin
      event_map <= '0;
    end else if (cfg_valid) begin
      event_map <= cfg_data;
    end
  end

  // Owner lookup: three bits per event id
  assign map_lsb = {1'b0, evt_id, 1'b0} + {2'b00, evt_id};
  assign owner   = event_map[map_lsb +: TASK_W];

  // Classify; only op bit 1 marks a query
  always_comb begin
    cmd.evt_id   = evt_id;
    cmd.arg      = arg;
    cmd.owner    = owner;
    priority if (op[1]) begin
      cmd.kind     = CMD_QUERY;
      cmd.task_sel = task_id;
    end else if (op == OP_POST) begin
      cmd.kind     = CMD_POST;
      cmd.task_sel = owner;
    end else begin
      cmd.kind     = CMD_POP;
      cmd.task_sel = task_id;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rpteq_cmd_fifo.sv =====
`default_nettype none

module rpteq_cmd_fifo
  import rpteq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output logic      full,
  output logic      valid,
  output cmd_t      head
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = entry[rd_ptr];

  // Two-entry command queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_cmd;
  end

endmodule

`default_nettype wire

// ===== rtl/rpteq_back.sv =====
`default_nettype none

module rpteq_back
  import rpteq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_valid,
  input  wire cmd_t                cmd,
  output logic                     cmd_take,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [2:0]               status,
  output logic [EVENT_W-1:0]       out_event_id,
  output logic [ARG_W-1:0]         out_arg,
  output logic [OTASK_W-1:0]       out_task,
  output logic                     notify,
  output logic [PTR_W-1:0]         head_pos,
  output logic [PTR_W-1:0]         tail_pos
);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t            state;
  logic [PTR_W-1:0]  front_ptr [TASK_COUNT];
  logic [PTR_W-1:0]  rear_ptr  [TASK_COUNT];
  logic [SLOT_W-1:0] store [TASK_COUNT * QUEUE_DEPTH];
  logic [SLOT_W-1:0] rd_data;

  logic [PTR_W-1:0]  cur_front;
  logic [PTR_W-1:0]  cur_rear;
  logic [PTR_W-1:0]  rear_inc;
  logic [PTR_W-1:0]  front_inc;
  logic              q_full;
  logic              q_empty;
  logic              out_free;
  logic              do_write;
  logic [TASK_W-1:0] pend_task;

  assign cur_front = front_ptr[cmd.task_sel];
  assign cur_rear  = rear_ptr[cmd.task_sel];
  assign rear_inc  = cur_rear + PTR_W'(1);
  assign front_inc = cur_front + PTR_W'(1);
  assign q_full    = (rear_inc == cur_front);
  assign q_empty   = (cur_front == cur_rear);

  // Take a command when the result register is free or draining
  assign out_free = !out_valid || !out_stall;
  assign cmd_take = cmd_valid && (state == S_IDLE) && out_free;
  assign do_write = cmd_take && (cmd.kind == CMD_POST) && !q_full;

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_write) store[{cmd.task_sel, cur_rear}] <= {cmd.evt_id, cmd.arg};
    rd_data <= store[{cmd.task_sel, cur_front}];
  end

  // Sequencer, pointers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < TASK_COUNT; i++) begin
        front_ptr[i] <= '0;
        rear_ptr[i]  <= '0;
      end
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_take) begin
            out_event_id <= '0;
            out_arg      <= '0;
            notify       <= 1'b0;
            unique case (cmd.kind)
              CMD_POST: begin
                out_valid <= 1'b1;
                out_task  <= {1'b0, cmd.task_sel};
                head_pos  <= cur_front;
                if (q_full) begin
                  status   <= ST_OVERFLOW;
                  tail_pos <= cur_rear;
                end else begin
                  status   <= ST_POSTED;
                  notify   <= 1'b1;
                  tail_pos <= rear_inc;
                  rear_ptr[cmd.task_sel] <= rear_inc;
                end
              end
              CMD_QUERY: begin
                out_valid <= 1'b1;
                status    <= ST_INFO;
                out_task  <= {1'b0, cmd.owner};
                head_pos  <= cur_front;
                tail_pos  <= cur_rear;
              end
              CMD_POP: begin
                tail_pos <= cur_rear;
                if (q_empty) begin
                  out_valid <= 1'b1;
                  status    <= ST_EMPTY;
                  out_task  <= TASK_NONE;
                  head_pos  <= cur_front;
                end else begin
                  head_pos  <= front_inc;
                  front_ptr[cmd.task_sel] <= front_inc;
                  pend_task <= cmd.task_sel;
                  state     <= S_READ;
                end
              end
              default: begin
                out_valid <= 1'b1;
                status    <= ST_INVALID;
                out_task  <= TASK_NONE;
                head_pos  <= '0;
                tail_pos  <= '0;
              end
            endcase
          end
        end
        S_READ: begin
          // slot data is registered, so it arrives in the cycle after the address
          out_valid    <= 1'b1;
          status       <= ST_DELIVERED;
          out_task     <= {1'b0, pend_task};
          out_event_id <= rd_data[SLOT_W-1 -: EVENT_W];
          out_arg      <= rd_data[ARG_W-1:0];
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/routed_per_task_event_queues_core.sv =====
`default_nettype none

// Channel   Handshake               Payload
// input     in_valid / in_stall     op, evt_id, arg, task_id
// output    out_valid / out_stall   status, out_event_id, out_arg, out_task,
//                                   notify, head_pos, tail_pos
// config    cfg_valid / cfg_ready   event_task_map
//
// A post or query is answered straight from the idle state; a pop that returns
// data also passes the read state, set by the registered read port of the slot memory.
// An item offered on the input passes the command queue and the result register.
// rst is synchronous: pointers, map, command queue and result valid are
// cleared; slot contents are left as they are.
// in_stall rises only when the two-entry command queue is full.

module routed_per_task_event_queues_core
  import rpteq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [MAP_W-1:0]   event_task_map,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         op,
  input  wire logic [EVENT_W-1:0] evt_id,
  input  wire logic [ARG_W-1:0]   arg,
  input  wire logic [TASK_W-1:0]  task_id,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              status,
  output logic [EVENT_W-1:0]      out_event_id,
  output logic [ARG_W-1:0]        out_arg,
  output logic [OTASK_W-1:0]      out_task,
  output logic                    notify,
  output logic [PTR_W-1:0]        head_pos,
  output logic [PTR_W-1:0]        tail_pos
);

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic fifo_full;
  logic fifo_valid;
  logic cmd_take;
  logic in_xfer;

  assign cfg_ready = 1'b1;
  assign in_stall  = fifo_full;
  assign in_xfer   = in_valid && !in_stall;

  rpteq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_data (event_task_map),
    .op       (op),
    .evt_id   (evt_id),
    .arg      (arg),
    .task_id  (task_id),
    .cmd      (front_cmd)
  );

  rpteq_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (in_xfer),
    .push_cmd(front_cmd),
    .pop     (cmd_take),
    .full    (fifo_full),
    .valid   (fifo_valid),
    .head    (head_cmd)
  );

  rpteq_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (fifo_valid),
    .cmd         (head_cmd),
    .cmd_take    (cmd_take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .out_event_id(out_event_id),
    .out_arg     (out_arg),
    .out_task    (out_task),
    .notify      (notify),
    .head_pos    (head_pos),
    .tail_pos    (tail_pos)
  );

  // notify goes with a successful post and nothing else
  a_notify_posted: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (notify == (status == ST_POSTED)))
    else $error("notify does not match posted status");

  // a delivered event always names its task
  a_deliver_task: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_DELIVERED) |-> (out_task != TASK_NONE))
    else $error("delivered event without task");

  // no command leaves the queue while it is empty
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> fifo_valid)
    else $error("command taken from empty queue");

  // reset clears the result valid flag
  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

// ===== test/task_queue_shadow.sv =====
`timescale 1ns / 1ps

// Shadow copy of the per-task event queues. Watches the three channels,
// predicts each reply from the accepted request and compares it field by
// field with the replies the block hands out.
module task_queue_shadow
  import rpteq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [MAP_W-1:0]   event_task_map,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [1:0]         op,
  input  wire logic [EVENT_W-1:0] evt_id,
  input  wire logic [ARG_W-1:0]   arg,
  input  wire logic [TASK_W-1:0]  task_id,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [2:0]         status,
  input  wire logic [EVENT_W-1:0] out_event_id,
  input  wire logic [ARG_W-1:0]   out_arg,
  input  wire logic [OTASK_W-1:0] out_task,
  input  wire logic               notify,
  input  wire logic [PTR_W-1:0]   head_pos,
  input  wire logic [PTR_W-1:0]   tail_pos,
  output int                      mismatches,
  output int                      in_flight
);

  typedef struct {
    status_t              st;
    logic [EVENT_W-1:0]   ev;
    logic [ARG_W-1:0]     word;
    logic [OTASK_W-1:0]   owner;
    logic                 note;
    logic [PTR_W-1:0]     head;
    logic [PTR_W-1:0]     tail;
  } reply_t;

  logic [MAP_W-1:0]   routing;
  logic [PTR_W-1:0]   head_ptr  [TASK_COUNT];
  logic [PTR_W-1:0]   tail_ptr  [TASK_COUNT];
  logic [EVENT_W-1:0] slot_ev   [TASK_COUNT*QUEUE_DEPTH];
  logic [ARG_W-1:0]   slot_word [TASK_COUNT*QUEUE_DEPTH];
  reply_t             awaited [$];
  int                 bad;

  // Apply one request to the shadow state and return the reply it must cause.
  // With eight tasks and sixteen events every id and every mapping names a
  // real queue, so the invalid-id status cannot come up here.
  function automatic reply_t serve_request(input logic [1:0] code,
                                           input logic [EVENT_W-1:0] ev,
                                           input logic [ARG_W-1:0] word,
                                           input logic [TASK_W-1:0] tid);
    reply_t               r;
    logic [TASK_W-1:0]    t;
    logic [PTR_W-1:0]     nxt;
    logic [STORE_AW-1:0]  at;
    r = '{st: ST_INVALID, ev: '0, word: '0, owner: TASK_NONE, note: 1'b0,
          head: '0, tail: '0};
    if (code[1]) begin
      // query: only bit 1 is decoded, so code 3 lands here too
      t = routing[3*ev +: TASK_W];
      r.st    = ST_INFO;
      r.owner = OTASK_W'(t);
      r.head  = head_ptr[tid];
      r.tail  = tail_ptr[tid];
    end else if (code == OP_POST) begin
      t = routing[3*ev +: TASK_W];
      nxt = tail_ptr[t] + PTR_W'(1);
      r.owner = OTASK_W'(t);
      if (nxt == head_ptr[t]) begin
        // one slot stays free: queue full, drop without moving anything
        r.st = ST_OVERFLOW;
      end else begin
        at = {t, tail_ptr[t]};
        slot_ev[at]   = ev;
        slot_word[at] = word;
        tail_ptr[t]   = nxt;
        r.st   = ST_POSTED;
        r.note = 1'b1;
      end
      r.head = head_ptr[t];
      r.tail = tail_ptr[t];
    end else begin
      // pop the front entry of the named queue
      if (head_ptr[tid] != tail_ptr[tid]) begin
        at = {tid, head_ptr[tid]};
        r.st    = ST_DELIVERED;
        r.ev    = slot_ev[at];
        r.word  = slot_word[at];
        r.owner = OTASK_W'(tid);
        head_ptr[tid] = head_ptr[tid] + PTR_W'(1);
      end else begin
        r.st = ST_EMPTY;
      end
      r.head = head_ptr[tid];
      r.tail = tail_ptr[tid];
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [ARG_W-1:0] want,
                             input logic [ARG_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      bad++;
    end
  endtask

  // Channel watch: config, request and reply transfers
  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      routing = '0;
      foreach (head_ptr[i]) begin
        head_ptr[i] = '0;
        tail_ptr[i] = '0;
      end
      awaited.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        routing = event_task_map;
      if (in_valid && !in_stall)
        awaited.push_back(serve_request(op, evt_id, arg, task_id));
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          $error("reply transfer with no request outstanding");
          bad++;
        end else begin
          want = awaited.pop_front();
          check_field("status", ARG_W'(want.st), ARG_W'(status));
          check_field("out_event_id", ARG_W'(want.ev), ARG_W'(out_event_id));
          check_field("out_arg", want.word, out_arg);
          check_field("out_task", ARG_W'(want.owner), ARG_W'(out_task));
          check_field("notify", ARG_W'(want.note), ARG_W'(notify));
          check_field("head_pos", ARG_W'(want.head), ARG_W'(head_pos));
          check_field("tail_pos", ARG_W'(want.tail), ARG_W'(tail_pos));
        end
      end
    end
    mismatches <= bad;
    in_flight  <= awaited.size();
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import rpteq_pkg::*;

  localparam logic [1:0] OP_QUERY     = 2'd2;
  localparam logic [1:0] OP_QUERY_ALT = 2'd3;
  localparam int NUM_EVENT_IDS = MAP_W / TASK_W;
  localparam int HOLD_CYCLES   = 80;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 100;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [MAP_W-1:0]   map_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         op;
  logic [EVENT_W-1:0] evt_id;
  logic [ARG_W-1:0]   arg;
  logic [TASK_W-1:0]  task_id;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         status;
  logic [EVENT_W-1:0] out_event_id;
  logic [ARG_W-1:0]   out_arg;
  logic [OTASK_W-1:0] out_task;
  logic               notify;
  logic [PTR_W-1:0]   head_pos;
  logic [PTR_W-1:0]   tail_pos;

  int                 mismatches;
  int                 in_flight;
  logic [MAP_W-1:0]   cur_map = '0;
  bit                 calm;
  bit                 hold_off_req;
  int                 n_post, n_pop, n_query, n_maps;

  routed_per_task_event_queues_core dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .event_task_map(map_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .evt_id(evt_id), .arg(arg), .task_id(task_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .out_event_id(out_event_id), .out_arg(out_arg),
    .out_task(out_task), .notify(notify), .head_pos(head_pos), .tail_pos(tail_pos)
  );

  task_queue_shadow shadow (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .event_task_map(map_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .evt_id(evt_id), .arg(arg), .task_id(task_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .out_event_id(out_event_id), .out_arg(out_arg),
    .out_task(out_task), .notify(notify), .head_pos(head_pos), .tail_pos(tail_pos),
    .mismatches(mismatches), .in_flight(in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: ends the run when no transfer happens for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Reply side: random stalls, a quiet stretch, and one long hold-off
  initial begin : reply_side
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        out_stall <= 1'b0;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 18);
      end
    end
  end

  // One request transfer, then maybe idle cycles; valid stays up when none follow
  task automatic send_item(input logic [1:0] o, input logic [EVENT_W-1:0] e,
                           input logic [ARG_W-1:0] a, input logic [TASK_W-1:0] t);
    in_valid <= 1'b1;
    op       <= o;
    evt_id   <= e;
    arg      <= a;
    task_id  <= t;
    do @(posedge clk); while (in_stall);
    if (o == OP_POST) n_post++;
    else if (o == OP_HANDLE) n_pop++;
    else n_query++;
    while (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Wait until every reply is back, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_map(input logic [MAP_W-1:0] m);
    cfg_valid <= 1'b1;
    map_wdata <= m;
    cur_map = m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_maps++;
  endtask

  // Map every event onto spread neighboring tasks from a random base so some queues fill up
  function automatic logic [MAP_W-1:0] spread_map(input int spread);
    logic [MAP_W-1:0]  m;
    logic [TASK_W-1:0] base;
    base = TASK_W'($urandom_range(TASK_COUNT-1));
    for (int e = 0; e < NUM_EVENT_IDS; e++)
      m[3*e +: TASK_W] = base + TASK_W'($urandom_range(spread-1));
    return m;
  endfunction

  task automatic send_random(input int post_pct);
    int                 roll;
    logic [EVENT_W-1:0] e;
    logic [TASK_W-1:0]  t;
    logic [1:0]         o;
    roll = $urandom_range(99);
    e = EVENT_W'($urandom);
    // half the pops and queries aim at a queue that posts actually reach
    t = $urandom_range(1) ? cur_map[3*e +: TASK_W] : TASK_W'($urandom);
    if (roll < post_pct) o = OP_POST;
    else if (roll < 85) o = OP_HANDLE;
    else o = ($urandom_range(3) == 0) ? OP_QUERY_ALT : OP_QUERY;
    send_item(o, e, $urandom, t);
  endtask

  initial begin : stimulus
    logic [MAP_W-1:0] m;
    in_valid  <= 1'b0;
    op        <= OP_POST;
    evt_id    <= '0;
    arg       <= '0;
    task_id   <= '0;
    cfg_valid <= 1'b0;
    map_wdata <= '0;
    rst       <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset map sends every event to task 0
    send_item(OP_QUERY, '0, '0, '0);
    send_item(OP_HANDLE, '0, '0, '0);
    send_item(OP_POST, '1, '1, '0);
    send_item(OP_POST, '0, '0, '1);
    send_item(OP_HANDLE, '0, '0, '0);
    send_item(OP_HANDLE, '0, '0, '0);
    send_item(OP_HANDLE, '1, '1, '0);
    send_item(OP_QUERY_ALT, 4'd9, '1, '1);
    drain();

    // Directed: all events to task 7, fill it past full, then free a slot
    write_map('1);
    for (int e = 0; e < NUM_EVENT_IDS; e++)
      send_item(OP_POST, EVENT_W'(e), $urandom, '0);
    send_item(OP_HANDLE, '0, '0, '1);
    send_item(OP_POST, '1, '0, '0);
    drain();

    // Random phases, each under its own routing map
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       m = '0;
        1:       m = '1;
        2:       m = spread_map(2);
        3:       m = spread_map(TASK_COUNT);
        4:       m = spread_map(1);
        5:       m = spread_map(4);
        6:       m = MAP_W'({$urandom, $urandom});
        default: m = spread_map(2);
      endcase
      write_map(m);
      calm = (phase == 4);
      if (phase == 2) hold_off_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_random((phase % 2 == 0) ? 60 : 30);
      drain();
    end
    calm = 1'b0;

    $display("Covered %0d posts, %0d pops, %0d queries under %0d routing maps,",
             n_post, n_pop, n_query, n_maps);
    $display("with random stalls on both sides and one long reply hold-off.");
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
